// ----- src/pid_ibc_pkg.sv -----
// Shared types and constants for the PID core with integral band clear.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package pid_ibc_pkg;

   localparam int ERR_W   = 24;
   localparam int DT_W    = 16;
   localparam int GAIN_W  = 32;
   localparam int BAND_W  = 23;
   localparam int INTEG_W = 32;
   localparam int DERIV_W = ERR_W + 1;
   localparam int DRIVE_W = 18;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int MUL_W  = 33;
   localparam int ACC_W  = 64;

   localparam logic [BAND_W-1:0] BAND_LOW_RST  = 23'd655;
   localparam logic [BAND_W-1:0] BAND_HIGH_RST = 23'd65536;
   localparam logic signed [ACC_W-17:0] DRIVE_MAX = 48'sd65536;
   localparam logic signed [ACC_W-17:0] DRIVE_MIN = -48'sd65536;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_PROP  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_DERIV = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_INTEG = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BAND_LOW   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BAND_HIGH  = 3'd4;

   // shared multiplier operand pair
   typedef enum logic [1:0] {
      MUL_ERR_DT,
      MUL_ERR_PROP,
      MUL_DERIV,
      MUL_INTEG
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD
   } acc_op_type;

   typedef struct packed {
      logic        load;
      mul_sel_type mul_sel;
      logic        upd_state;
      acc_op_type  acc_op;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic out_busy;
   } status_type;

endpackage

// ----- src/pid_ibc_ctrl.sv -----
// Sequencer for the PID core: walks one transaction through the shared multiplier.
// Depends on pid_ibc_pkg for the command and status structs.
`timescale 1ns / 1ps

module pid_ibc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  pid_ibc_pkg::status_type status,
   output pid_ibc_pkg::cmd_type    cmd
);
   import pid_ibc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_DT,
      ST_UPD_I,
      ST_MUL_D,
      ST_MUL_I,
      ST_SUM,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   // decode commands from the current state
   always_comb begin
      cmd       = '0;
      cmd.mul_sel = MUL_ERR_DT;
      cmd.acc_op  = ACC_HOLD;
      state_in  = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = req_valid;
            if (req_valid) state_in = ST_MUL_DT;
         end
         ST_MUL_DT: begin
            cmd.mul_sel = MUL_ERR_DT;
            state_in    = ST_UPD_I;
         end
         ST_UPD_I: begin
            cmd.upd_state = 1'b1;
            cmd.mul_sel   = MUL_ERR_PROP;
            state_in      = ST_MUL_D;
         end
         ST_MUL_D: begin
            cmd.acc_op  = ACC_LOAD;
            cmd.mul_sel = MUL_DERIV;
            state_in    = ST_MUL_I;
         end
         ST_MUL_I: begin
            cmd.acc_op  = ACC_ADD;
            cmd.mul_sel = MUL_INTEG;
            state_in    = ST_SUM;
         end
         ST_SUM: begin
            cmd.acc_op = ACC_ADD;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            // wait for the output register to free up
            if (!status.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // a result is only written into a free output register
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !status.out_busy)
      else $error("result loaded over a pending transaction");

   // every accepted transaction reaches the integral update by way of ST_MUL_DT
   a_load_upd: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> ##2 cmd.upd_state)
      else $error("integral update missed after accept");

   // accumulator is loaded before it is added to
   a_acc_order: assert property (@(posedge clock) disable iff (reset)
      (cmd.acc_op == ACC_LOAD) |=> (cmd.acc_op == ACC_ADD))
      else $error("accumulator sequence broken");

endmodule

// ----- src/pid_ibc_dpath.sv -----
// Datapath for the PID core: config registers, loop state, shared multiplier,
// 64 bit accumulator and output register. Depends on pid_ibc_pkg.
`timescale 1ns / 1ps

module pid_ibc_dpath (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_wr_en,
   input  logic [pid_ibc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pid_ibc_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic signed [pid_ibc_pkg::ERR_W-1:0]    req_error_sample,
   input  logic [pid_ibc_pkg::DT_W-1:0]            req_time_step,
   output logic signed [pid_ibc_pkg::DRIVE_W-1:0]  rsp_drive,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   input  pid_ibc_pkg::cmd_type                    cmd,
   output pid_ibc_pkg::status_type                 status
);
   import pid_ibc_pkg::*;

   logic signed [GAIN_W-1:0]  gain_prop_ff, gain_deriv_ff, gain_integ_ff;
   logic [BAND_W-1:0]         band_low_ff, band_high_ff;
   logic                      started_ff;
   logic signed [ERR_W-1:0]   last_error_ff;
   logic signed [INTEG_W-1:0] integ_ff, integ_in;
   logic signed [ERR_W-1:0]   err_ff;
   logic [DT_W-1:0]           dt_ff;
   logic signed [DERIV_W-1:0] deriv_ff, deriv_in;
   logic signed [MUL_W-1:0]   op_a, op_b;
   logic signed [2*MUL_W-1:0] prod_full;
   logic signed [ACC_W-1:0]   prod_ff, acc_ff, acc_in;
   logic signed [ACC_W-17:0]  scaled, clamped;
   logic signed [DRIVE_W-1:0] drive_ff;
   logic                      valid_ff;
   logic [ERR_W-1:0]          mag;
   logic                      band_clear;
   logic signed [INTEG_W+1:0] integ_sum;
   logic signed [ACC_W-13:0]  inc;

   // write configuration registers; unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_prop_ff  <= '0;
         gain_deriv_ff <= '0;
         gain_integ_ff <= '0;
         band_low_ff   <= BAND_LOW_RST;
         band_high_ff  <= BAND_HIGH_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_GAIN_PROP:  gain_prop_ff  <= csr_wdata;
            CSR_GAIN_DERIV: gain_deriv_ff <= csr_wdata;
            CSR_GAIN_INTEG: gain_integ_ff <= csr_wdata;
            CSR_BAND_LOW:   band_low_ff   <= csr_wdata[BAND_W-1:0];
            CSR_BAND_HIGH:  band_high_ff  <= csr_wdata[BAND_W-1:0];
            default: ;
         endcase
      end
   end

   // capture the input transaction
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         err_ff <= req_error_sample;
         dt_ff  <= req_time_step;
      end
   end

   // band check and saturating integral step
   always_comb begin
      mag        = err_ff[ERR_W-1] ? ERR_W'(-err_ff) : ERR_W'(err_ff);
      band_clear = (mag < {1'b0, band_low_ff}) || (mag > {1'b0, band_high_ff});
      inc        = prod_ff[ACC_W-1:12];
      integ_sum  = (INTEG_W+2)'(integ_ff) + (INTEG_W+2)'($signed(inc[INTEG_W-1:0]));
      if (!started_ff || band_clear) begin
         integ_in = '0;
      end else if (integ_sum > (INTEG_W+2)'(34'sh0_7FFF_FFFF)) begin
         integ_in = {1'b0, {(INTEG_W-1){1'b1}}};
      end else if (integ_sum < -(INTEG_W+2)'(34'sh0_8000_0000)) begin
         integ_in = {1'b1, {(INTEG_W-1){1'b0}}};
      end else begin
         integ_in = integ_sum[INTEG_W-1:0];
      end
      deriv_in = started_ff ? (DERIV_W'(err_ff) - DERIV_W'(last_error_ff)) : '0;
   end

   // advance loop state once per transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff    <= 1'b0;
         last_error_ff <= '0;
         integ_ff      <= '0;
      end else if (cmd.upd_state) begin
         started_ff    <= 1'b1;
         last_error_ff <= err_ff;
         integ_ff      <= integ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.upd_state) deriv_ff <= deriv_in;
   end

   // select operands for the shared multiplier
   always_comb begin
      case (cmd.mul_sel)
         MUL_ERR_DT: begin
            op_a = MUL_W'(err_ff);
            op_b = $signed({{(MUL_W-DT_W){1'b0}}, dt_ff});
         end
         MUL_ERR_PROP: begin
            op_a = MUL_W'(err_ff);
            op_b = MUL_W'(gain_prop_ff);
         end
         MUL_DERIV: begin
            op_a = MUL_W'(deriv_ff);
            op_b = MUL_W'(gain_deriv_ff);
         end
         default: begin
            op_a = MUL_W'(integ_ff);
            op_b = MUL_W'(gain_integ_ff);
         end
      endcase
      prod_full = op_a * op_b;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_full[ACC_W-1:0];
      acc_ff  <= acc_in;
   end

   // accumulate the three gain products
   always_comb begin
      case (cmd.acc_op)
         ACC_LOAD: acc_in = prod_ff;
         ACC_ADD:  acc_in = acc_ff + prod_ff;
         default:  acc_in = acc_ff;
      endcase
      scaled = acc_ff[ACC_W-1:16];
      if (scaled > DRIVE_MAX)      clamped = DRIVE_MAX;
      else if (scaled < DRIVE_MIN) clamped = DRIVE_MIN;
      else                         clamped = scaled;
   end

   // output register: load a negated drive, drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) drive_ff <= DRIVE_W'(-clamped);
   end

   assign rsp_drive       = drive_ff;
   assign rsp_valid       = valid_ff;
   assign status.out_busy = valid_ff && !rsp_ready;

   // the drive never leaves plus or minus one
   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_drive <= 18'sd65536 && rsp_drive >= -18'sd65536))
      else $error("drive out of range");

   // a loaded result shows up on the next cycle
   a_out_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid)
      else $error("result not presented");

   // a cleared band leaves the integral at zero
   a_band_clear: assert property (@(posedge clock) disable iff (reset)
      (cmd.upd_state && band_clear) |=> (integ_ff == '0))
      else $error("integral not cleared outside band");

endmodule

// ----- src/pid_with_integral_band_clamp_core.sv -----
// PID controller core with integral band clear and output clamp.
//
// Channels: req_ carries one error sample (Q8.16) and time step (Q4.12) per
// transaction on valid/ready; rsp_ returns one drive value (Q2.16, negated and
// clamped to plus or minus one) per transaction on valid/ready. csr_ is a plain
// write port: gains at indexes 0..2, band low/high at 3 and 4; other indexes
// are ignored. Write it only while the core is idle.
// One transaction is in work at a time and the next is accepted on the cycle
// after its result is loaded. The schedule follows the single shared 33x33
// multiplier, used four times in order (error times step and the three gain
// products), plus the integral update and the final sum.
// The output register lets a new request be accepted while a result waits.
// If rsp_ready stays low, the next result waits in the datapath and req_ready
// stays low until the output register frees up.
// Reset (synchronous, active high) clears the gains, restores the band edges
// to 655 and 65536, zeroes the integral and last error, and marks the next
// sample as the first one (no derivative, no integral).
`timescale 1ns / 1ps

module pid_with_integral_band_clamp_core (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_wr_en,
   input  logic [pid_ibc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pid_ibc_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [pid_ibc_pkg::ERR_W-1:0]    req_error_sample,
   input  logic [pid_ibc_pkg::DT_W-1:0]            req_time_step,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [pid_ibc_pkg::DRIVE_W-1:0]  rsp_drive
);
   import pid_ibc_pkg::*;

   cmd_type    cmd;
   status_type status;

   pid_ibc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pid_ibc_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_error_sample (req_error_sample),
      .req_time_step    (req_time_step),
      .rsp_drive        (rsp_drive),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .cmd              (cmd),
      .status           (status)
   );

endmodule
